### rtl/pcv_pkg.sv
// Shared types and constants for the partition communication volume block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package pcv_pkg;

    localparam int NodeBlocks = 64;
    localparam int BlockWidth = 6;
    localparam int WeightWidth = 31;
    localparam int CountWidth = 7;
    localparam int CutWidth = 63;
    localparam int CfgWidth = 7;
    localparam int OutWidth = 32;
    localparam int CutOutWidth = 62;
    localparam int InDataWidth = 48;
    localparam int OutDataWidth = 160;
    localparam logic [CfgWidth-1:0] BlocksReset = 7'd2;
    localparam logic [CutWidth-1:0] CutMax = {CutWidth{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RMW,
        ST_WALK,
        ST_WALK_END,
        ST_RESULT,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic edge_accept;
        logic finish_start;
        logic rmw_write;
        logic walk_read;
        logic result_load;
        logic clear_write;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_finish;
        logic needs_rmw;
        logic walk_done;
        logic clear_done;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/pcv_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Self-contained; no package dependencies.
`timescale 1ns / 1ps

module pcv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pcv_ctrl.sv
// Control state machine: sequences edge updates, the finish walk and the table clear.
// Depends on pcv_pkg for the state, command and status types.
`timescale 1ns / 1ps

module pcv_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pcv_pkg::dp_status_t status,
    output pcv_pkg::ctrl_cmd_t  cmd
);

    import pcv_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        accept     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                accept   = s_tvalid;
                if (accept)
                begin
                    if (status.is_finish)
                    begin
                        cmd.finish_start = 1'b1;
                        state_next       = ST_WALK;
                    end
                    else
                    begin
                        cmd.edge_accept = 1'b1;
                        if (status.needs_rmw)
                        begin
                            state_next = ST_RMW;
                        end
                    end
                end
            end
            ST_RMW:
            begin
                cmd.rmw_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_WALK:
            begin
                cmd.walk_read = 1'b1;
                if (status.walk_done)
                begin
                    state_next = ST_WALK_END;
                end
            end
            ST_WALK_END:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/pcv_datapath.sv
// Datapath: node foreign-block set, cut accumulator, volume table and reduction.
// Depends on pcv_pkg and instantiates pcv_ram for the volume table.
`timescale 1ns / 1ps

module pcv_datapath #(
    parameter int MAX_BLOCKS = 64,
    parameter int VOLUME_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [pcv_pkg::InDataWidth-1:0]     s_tdata,
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    input  logic                                cfg_valid,
    input  logic [pcv_pkg::CfgWidth-1:0]        cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pcv_pkg::OutDataWidth-1:0]    m_tdata,
    output logic                                m_tuser,
    input  pcv_pkg::ctrl_cmd_t                  cmd,
    output pcv_pkg::dp_status_t                 status
);

    import pcv_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int VW = VOLUME_WIDTH;

    logic [BlockWidth-1:0]  src_block;
    logic [BlockWidth-1:0]  dst_block;
    logic [WeightWidth-1:0] weight;
    logic                   src_in_range;
    logic [AW-1:0]          src_addr;

    logic [CfgWidth-1:0]    blocks_reg;
    logic [NodeBlocks-1:0]  touched_reg;
    logic [CountWidth-1:0]  count_reg;
    logic [CountWidth-1:0]  count_next;
    logic [CutWidth-1:0]    cut_reg;
    logic [CutWidth:0]      cut_sum;
    logic                   ovf_reg;
    logic [AW-1:0]          rmw_addr_reg;
    logic [CountWidth-1:0]  rmw_count_reg;
    logic [AW-1:0]          idx_reg;
    logic [AW-1:0]          klast_reg;
    logic [31:0]            k_int;
    logic                   walk_rd_reg;
    logic                   first_reg;
    logic [VW-1:0]          mx_reg;
    logic [VW-1:0]          mn_reg;
    logic [OutWidth-1:0]    tot_reg;
    logic                   tovf_reg;

    logic                   diff;
    logic                   is_new;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VW-1:0]          ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [VW-1:0]          ram_rdata;
    logic [VW:0]            vol_sum;
    logic [VW-1:0]          vol_new;

    logic [63:0]            v_ext;
    logic                   v_big;
    logic [OutWidth:0]      tot_sum;
    logic [63:0]            mx_ext;
    logic [63:0]            mn_ext;
    logic [OutWidth-1:0]    mx_out;
    logic [OutWidth-1:0]    mn_out;
    logic                   mx_big;
    logic                   mn_big;

    logic                   m_tvalid_reg;
    logic [OutDataWidth-1:0] m_tdata_reg;
    logic                   m_tuser_reg;

    assign src_block = s_tdata[BlockWidth-1:0];
    assign dst_block = s_tdata[2*BlockWidth-1:BlockWidth];
    assign weight    = s_tdata[2*BlockWidth+WeightWidth-1:2*BlockWidth];
    assign src_in_range = 32'(src_block) < 32'(MAX_BLOCKS);
    assign src_addr  = AW'(src_block);

    assign diff       = src_block != dst_block;
    assign is_new     = diff && !touched_reg[dst_block];
    assign count_next = count_reg + CountWidth'(is_new);
    assign cut_sum    = {1'b0, cut_reg} + (CutWidth + 1)'(weight);

    always_comb
    begin
        if (blocks_reg == '0)
        begin
            k_int = 32'd1;
        end
        else if (32'(blocks_reg) > 32'(MAX_BLOCKS))
        begin
            k_int = 32'(MAX_BLOCKS);
        end
        else
        begin
            k_int = 32'(blocks_reg);
        end
    end

    assign ram_re    = cmd.edge_accept || cmd.walk_read;
    assign ram_raddr = cmd.walk_read ? idx_reg : src_addr;
    assign ram_we    = cmd.rmw_write || cmd.clear_write;
    assign ram_waddr = cmd.clear_write ? idx_reg : rmw_addr_reg;
    assign vol_sum   = {1'b0, ram_rdata} + (VW + 1)'(rmw_count_reg);
    assign vol_new   = vol_sum[VW] ? {VW{1'b1}} : vol_sum[VW-1:0];
    assign ram_wdata = cmd.clear_write ? '0 : vol_new;

    pcv_ram #(
        .WIDTH(VW),
        .DEPTH(MAX_BLOCKS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign v_ext   = 64'(ram_rdata);
    assign v_big   = |v_ext[63:OutWidth];
    assign tot_sum = {1'b0, tot_reg} + {1'b0, v_ext[OutWidth-1:0]};

    assign mx_ext = 64'(mx_reg);
    assign mn_ext = 64'(mn_reg);
    assign mx_big = |mx_ext[63:OutWidth];
    assign mn_big = |mn_ext[63:OutWidth];
    assign mx_out = mx_big ? {OutWidth{1'b1}} : mx_ext[OutWidth-1:0];
    assign mn_out = mn_big ? {OutWidth{1'b1}} : mn_ext[OutWidth-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_reg   <= BlocksReset;
            touched_reg  <= '0;
            count_reg    <= '0;
            cut_reg      <= '0;
            ovf_reg      <= 1'b0;
            idx_reg      <= '0;
            walk_rd_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            walk_rd_reg <= cmd.walk_read;
            if (cfg_valid)
            begin
                blocks_reg <= cfg_data;
            end
            if (cmd.edge_accept)
            begin
                if (diff)
                begin
                    if (cut_sum > {1'b0, CutMax})
                    begin
                        cut_reg <= CutMax;
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        cut_reg <= cut_sum[CutWidth-1:0];
                    end
                end
                if (s_tlast)
                begin
                    touched_reg <= '0;
                    count_reg   <= '0;
                end
                else
                begin
                    if (diff)
                    begin
                        touched_reg[dst_block] <= 1'b1;
                    end
                    count_reg <= count_next;
                end
            end
            if (cmd.rmw_write && vol_sum[VW])
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.finish_start || cmd.result_load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.walk_read || cmd.clear_write)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            if (cmd.result_load)
            begin
                touched_reg  <= '0;
                count_reg    <= '0;
                cut_reg      <= '0;
                ovf_reg      <= 1'b0;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.edge_accept)
        begin
            rmw_addr_reg  <= src_addr;
            rmw_count_reg <= count_next;
        end
        if (cmd.finish_start)
        begin
            klast_reg <= AW'(k_int - 32'd1);
            first_reg <= 1'b1;
            tot_reg   <= '0;
            tovf_reg  <= 1'b0;
        end
        else if (walk_rd_reg)
        begin
            first_reg <= 1'b0;
            if (first_reg || ram_rdata > mx_reg)
            begin
                mx_reg <= ram_rdata;
            end
            if (first_reg || ram_rdata < mn_reg)
            begin
                mn_reg <= ram_rdata;
            end
            if (v_big || tot_sum[OutWidth])
            begin
                tot_reg  <= {OutWidth{1'b1}};
                tovf_reg <= 1'b1;
            end
            else
            begin
                tot_reg <= tot_sum[OutWidth-1:0];
            end
        end
        if (cmd.result_load)
        begin
            m_tdata_reg <= {2'b00, cut_reg[CutWidth-1:1], tot_reg, mn_out, mx_out};
            m_tuser_reg <= ovf_reg || tovf_reg || mx_big || mn_big;
        end
    end

    assign status.is_finish  = s_tuser;
    assign status.needs_rmw  = s_tlast && src_in_range;
    assign status.walk_done  = idx_reg == klast_reg;
    assign status.clear_done = idx_reg == AW'(MAX_BLOCKS - 1);
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### rtl/partition_communication_volume.sv
// Top level of the partition communication volume and edge cut accumulator.
// Edge words are taken one per cycle while the controller is idle; an edge word that
// closes a node whose block is in the table is followed by a table read-modify-write
// state that takes no word. A finish word walks the first k table entries, k
// being blocks_in_use clamped to 1..MAX_BLOCKS, then presents its result.
// A full table clear follows, as after reset; configuration is taken at any time.
`timescale 1ns / 1ps

module partition_communication_volume #(
    parameter int MAX_BLOCKS = 64,
    parameter int VOLUME_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // source_block [5:0], dest_block [11:6], edge_weight [42:12], zero fill
    input  logic [pcv_pkg::InDataWidth-1:0]  s_tdata,
    // command [0]
    input  logic                             s_tuser,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // max_volume [31:0], min_volume [63:32], volume_sum [95:64],
    // cut_weight [157:96], zero fill
    output logic [pcv_pkg::OutDataWidth-1:0] m_tdata,
    // overflow [0]
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pcv_pkg::CfgWidth-1:0]     cfg_data
);

    import pcv_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    pcv_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    pcv_datapath #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .VOLUME_WIDTH(VOLUME_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

### rtl/pcv_checker.sv
// Port-level checker for the partition communication volume block, bound to the top level.
// Depends on pcv_pkg for the word widths.
`timescale 1ns / 1ps

module pcv_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [pcv_pkg::OutDataWidth-1:0] m_tdata,
    input logic                             m_tuser
);

    // A stalled result word holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A finish word starts the table walk, so no word is taken in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input accepted right after a finish word");

    // A new result appears while the table clear is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !s_tready)
        else $error("input ready while a result is being produced");

    // The minimum volume never exceeds the maximum volume.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[63:32] <= m_tdata[31:0])
        else $error("min_volume above max_volume");

endmodule

bind partition_communication_volume pcv_checker u_pcv_checker (.*);
